// ----- hw/rtl/h4rx_pkg.sv -----
// ----------------------------------------------------------------------------
// h4rx_pkg
// Shared types and codes for the HCI H4 receive deframer.
// ----------------------------------------------------------------------------
package h4rx_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] TYPE_INIT = 8'h00;
    localparam logic [7:0] TYPE_ACL  = 8'h02;
    localparam logic [7:0] TYPE_SCO  = 8'h03;
    localparam logic [7:0] TYPE_EVT  = 8'h04;

    localparam logic [1:0] KIND_ACL  = 2'd0;
    localparam logic [1:0] KIND_SCO  = 2'd1;
    localparam logic [1:0] KIND_EVT  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] ST_PART    = 2'd0;
    localparam logic [1:0] ST_INIT    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_DISCARD = 2'd3;

    typedef enum logic [2:0] {
        TC_INIT = 3'd0,
        TC_ACL  = 3'd1,
        TC_SCO  = 3'd2,
        TC_EVT  = 3'd3,
        TC_BAD  = 3'd4
    } type_class_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        window_end;
        type_class_t tclass;
    } entry_t;

    typedef enum logic [6:0] {
        PH_TYPE    = 7'b0000001,
        PH_ACL_HDR = 7'b0000010,
        PH_SCO_HDR = 7'b0000100,
        PH_EVT_HDR = 7'b0001000,
        PH_ACL_DAT = 7'b0010000,
        PH_SCO_DAT = 7'b0100000,
        PH_EVT_DAT = 7'b1000000
    } phase_t;

endpackage

// ----- hw/rtl/h4rx_front.sv -----
// ----------------------------------------------------------------------------
// h4rx_front
// Accept received bytes and classify each as a possible packet type byte.
// ----------------------------------------------------------------------------
module h4rx_front (
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      rx_byte,
    input  logic            window_end,
    output logic            push_valid,
    input  logic            push_ready,
    output h4rx_pkg::entry_t push_entry
);

    h4rx_pkg::type_class_t tclass;

    always_comb
    begin
        case (rx_byte)
            h4rx_pkg::TYPE_INIT: tclass = h4rx_pkg::TC_INIT;
            h4rx_pkg::TYPE_ACL:  tclass = h4rx_pkg::TC_ACL;
            h4rx_pkg::TYPE_SCO:  tclass = h4rx_pkg::TC_SCO;
            h4rx_pkg::TYPE_EVT:  tclass = h4rx_pkg::TC_EVT;
            default:             tclass = h4rx_pkg::TC_BAD;
        endcase
    end

    assign push_valid            = in_valid;
    assign in_ready              = push_ready;
    assign push_entry.data       = rx_byte;
    assign push_entry.window_end = window_end;
    assign push_entry.tclass     = tclass;

endmodule

// ----- hw/rtl/h4rx_queue.sv -----
// ----------------------------------------------------------------------------
// h4rx_queue
// Short queue of classified beats between the front and back parts.
// ----------------------------------------------------------------------------
module h4rx_queue #(
    parameter int DEPTH = h4rx_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  h4rx_pkg::entry_t push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output h4rx_pkg::entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    h4rx_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hw/rtl/h4rx_back.sv -----
// ----------------------------------------------------------------------------
// h4rx_back
// Track packet phase, tag each beat, and hold the result in an output register.
// ----------------------------------------------------------------------------
module h4rx_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  h4rx_pkg::entry_t pop_entry,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       packet_kind,
    output logic             first_of_packet,
    output logic             last_of_packet,
    output logic [1:0]       byte_status
);

    h4rx_pkg::phase_t phase_reg, phase_next;
    logic [15:0] wanted_reg, wanted_next;
    logic [1:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic        discard_reg, discard_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [1:0]  kind_reg, kind_next;
    logic        first_reg, first_next;
    logic        last_reg, last_next;
    logic [1:0]  status_reg, status_next;

    logic        pop;
    logic [7:0]  b;
    logic        wend;
    logic [15:0] hdr_len;
    logic        hdr_done;
    h4rx_pkg::phase_t data_phase;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;
    assign b         = pop_entry.data;
    assign wend      = pop_entry.window_end;

    always_comb
    begin
        phase_next   = phase_reg;
        wanted_next  = wanted_reg;
        hdr_idx_next = hdr_idx_reg;
        len_low_next = len_low_reg;
        discard_next = discard_reg;
        kind_next    = h4rx_pkg::KIND_NONE;
        status_next  = h4rx_pkg::ST_PART;
        first_next   = 1'b0;
        last_next    = 1'b0;
        hdr_done     = 1'b0;
        hdr_len      = 16'd0;
        data_phase   = h4rx_pkg::PH_TYPE;

        if (discard_reg)
        begin
            status_next = h4rx_pkg::ST_DISCARD;
            if (wend)
            begin
                discard_next = 1'b0;
            end
        end
        else
        begin
            case (phase_reg)
                h4rx_pkg::PH_ACL_HDR:
                begin
                    kind_next = h4rx_pkg::KIND_ACL;
                    if (hdr_idx_reg == 2'd2)
                    begin
                        len_low_next = b;
                    end
                    if (hdr_idx_reg == 2'd3)
                    begin
                        hdr_done   = 1'b1;
                        hdr_len    = {b, len_low_reg};
                        data_phase = h4rx_pkg::PH_ACL_DAT;
                    end
                    else
                    begin
                        hdr_idx_next = hdr_idx_reg + 1'b1;
                    end
                end
                h4rx_pkg::PH_SCO_HDR:
                begin
                    kind_next = h4rx_pkg::KIND_SCO;
                    if (hdr_idx_reg >= 2'd2)
                    begin
                        hdr_done   = 1'b1;
                        hdr_len    = {8'd0, b};
                        data_phase = h4rx_pkg::PH_SCO_DAT;
                    end
                    else
                    begin
                        hdr_idx_next = hdr_idx_reg + 1'b1;
                    end
                end
                h4rx_pkg::PH_EVT_HDR:
                begin
                    kind_next = h4rx_pkg::KIND_EVT;
                    if (hdr_idx_reg >= 2'd1)
                    begin
                        hdr_done   = 1'b1;
                        hdr_len    = {8'd0, b};
                        data_phase = h4rx_pkg::PH_EVT_DAT;
                    end
                    else
                    begin
                        hdr_idx_next = hdr_idx_reg + 1'b1;
                    end
                end
                h4rx_pkg::PH_ACL_DAT,
                h4rx_pkg::PH_SCO_DAT,
                h4rx_pkg::PH_EVT_DAT:
                begin
                    kind_next = (phase_reg == h4rx_pkg::PH_ACL_DAT) ? h4rx_pkg::KIND_ACL :
                                (phase_reg == h4rx_pkg::PH_SCO_DAT) ? h4rx_pkg::KIND_SCO :
                                                                      h4rx_pkg::KIND_EVT;
                    if (wanted_reg <= 16'd1)
                    begin
                        wanted_next = 16'd0;
                        phase_next  = h4rx_pkg::PH_TYPE;
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        wanted_next = wanted_reg - 1'b1;
                    end
                end
                default:
                begin
                    phase_next   = h4rx_pkg::PH_TYPE;
                    hdr_idx_next = 2'd0;
                    case (pop_entry.tclass)
                        h4rx_pkg::TC_INIT:
                        begin
                            status_next = h4rx_pkg::ST_INIT;
                        end
                        h4rx_pkg::TC_ACL:
                        begin
                            kind_next  = h4rx_pkg::KIND_ACL;
                            first_next = 1'b1;
                            phase_next = h4rx_pkg::PH_ACL_HDR;
                        end
                        h4rx_pkg::TC_SCO:
                        begin
                            kind_next  = h4rx_pkg::KIND_SCO;
                            first_next = 1'b1;
                            phase_next = h4rx_pkg::PH_SCO_HDR;
                        end
                        h4rx_pkg::TC_EVT:
                        begin
                            kind_next  = h4rx_pkg::KIND_EVT;
                            first_next = 1'b1;
                            phase_next = h4rx_pkg::PH_EVT_HDR;
                        end
                        default:
                        begin
                            status_next  = h4rx_pkg::ST_ERROR;
                            discard_next = !wend;
                        end
                    endcase
                end
            endcase

            if (hdr_done)
            begin
                hdr_idx_next = 2'd0;
                wanted_next  = hdr_len;
                if (hdr_len == 16'd0)
                begin
                    phase_next = h4rx_pkg::PH_TYPE;
                    last_next  = 1'b1;
                end
                else
                begin
                    phase_next = data_phase;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= h4rx_pkg::PH_TYPE;
            wanted_reg    <= 16'd0;
            hdr_idx_reg   <= 2'd0;
            len_low_reg   <= 8'd0;
            discard_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg   <= phase_next;
                wanted_reg  <= wanted_next;
                hdr_idx_reg <= hdr_idx_next;
                len_low_reg <= len_low_next;
                discard_reg <= discard_next;
            end
            if (pop_ready)
            begin
                out_valid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_byte_reg <= b;
            kind_reg     <= kind_next;
            first_reg    <= first_next;
            last_reg     <= last_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign packet_kind     = kind_reg;
    assign first_of_packet = first_reg;
    assign last_of_packet  = last_reg;
    assign byte_status     = status_reg;

    a_first_tagged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && first_reg |->
            kind_reg != h4rx_pkg::KIND_NONE && status_reg == h4rx_pkg::ST_PART)
        else $error("first mark on a beat outside a packet");

    a_last_tagged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |->
            kind_reg != h4rx_pkg::KIND_NONE && status_reg == h4rx_pkg::ST_PART)
        else $error("last mark on a beat outside a packet");

    a_discard_phase: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> phase_reg == h4rx_pkg::PH_TYPE)
        else $error("discarding while inside a packet");

    a_data_wanted: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == h4rx_pkg::PH_ACL_DAT || phase_reg == h4rx_pkg::PH_SCO_DAT ||
         phase_reg == h4rx_pkg::PH_EVT_DAT) |-> wanted_reg != 16'd0)
        else $error("data phase with no bytes wanted");

endmodule

// ----- hw/rtl/hci_h4_receive_deframer.sv -----
// ----------------------------------------------------------------------------
// hci_h4_receive_deframer
// Split a received byte stream into HCI H4 packets and tag every byte.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and gives one tagged byte per
// cycle while the output is not stalled, every byte yielding exactly one
// result. The front classifies the type code of an accepted byte
// combinationally and the byte is written to a short queue; the back then
// applies the packet phase update as the byte leaves the queue and loads
// the output register. The phase update sets the sustained rate of one byte
// per cycle; the queue lets the input keep flowing for up to QUEUE_DEPTH
// bytes while the output is stalled.
module hci_h4_receive_deframer #(
    parameter int QUEUE_DEPTH = h4rx_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       window_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] packet_kind,
    output logic       first_of_packet,
    output logic       last_of_packet,
    output logic [1:0] byte_status
);

    logic             push_valid, push_ready;
    logic             pop_valid, pop_ready;
    h4rx_pkg::entry_t push_entry, pop_entry;

    h4rx_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .window_end (window_end),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    h4rx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    h4rx_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_entry       (pop_entry),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .packet_kind     (packet_kind),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet),
        .byte_status     (byte_status)
    );

endmodule
